// ===== rtl/core/rc5_pkg.sv =====
package rc5_pkg;

   // Key expansion magic constants
   localparam logic [31:0] MAGIC_P = 32'hb7e15163;
   localparam logic [31:0] MAGIC_Q = 32'h9e3779b9;

   // Item modes carried in req_tuser
   typedef logic [1:0] mode_type;
   localparam mode_type MODE_EXPAND  = 2'd0;
   localparam mode_type MODE_ENCRYPT = 2'd1;
   localparam mode_type MODE_DECRYPT = 2'd2;
   localparam mode_type MODE_UNUSED  = 2'd3;   // no operation, zero result

   // Configuration register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_KEY_WORD_0 = 3'd0;
   localparam csr_index_type CSR_KEY_WORD_1 = 3'd1;
   localparam csr_index_type CSR_KEY_WORD_2 = 3'd2;
   localparam csr_index_type CSR_KEY_WORD_3 = 3'd3;
   localparam csr_index_type CSR_KEY_LENGTH = 3'd4;

   localparam int          KEY_WORDS     = 4;
   localparam logic [4:0]  MAX_KEY_BYTES = 5'd16;
   localparam logic [4:0]  KEY_LEN_RESET = 5'd4;

   // Rotate left, amount taken modulo 32
   function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   // Rotate right, amount taken modulo 32
   function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} >> n;
      return d[31:0];
   endfunction

endpackage

// ===== rtl/core/rc5_ram.sv =====
module rc5_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 26
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rc5_block_cipher.sv =====
// RC5-32/ROUNDS block cipher with a key of up to 16 bytes. Each transfer on the req_ side
// carries a mode: expand the configured key into the subkey table, encrypt one 64-bit block or
// decrypt one; each gives exactly one transfer on the rsp_ side (zero data with the flag set
// for an expansion, zero data for the unused mode). The subkey table of 2*(ROUNDS+1) words sits
// in a single-port-read RAM, so a block reads one subkey per cycle and does one half-round per
// cycle. Key expansion first loads the initial table word by word, then runs 3*(2*(ROUNDS+1))
// mixing steps, each a subkey update followed by a key word update with its variable rotate.
// The table reads as all zero after reset until the first expansion has loaded it. Key
// registers may be written only while the block is idle.
module rc5_block_cipher #(
   parameter int ROUNDS = 12
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] block_a, [63:32] block_b
   input  logic [1:0]  req_tuser,   // [1:0] mode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] result_a, [63:32] result_b
   output logic        rsp_tuser,   // [0] expand_done
   // configuration
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
   localparam int IW          = $clog2(TABLE_WORDS);
   localparam int MIX_STEPS   = 3 * TABLE_WORDS;
   localparam int SW          = $clog2(MIX_STEPS);
   localparam logic [IW-1:0] IDX_LAST  = IW'(TABLE_WORDS - 1);
   localparam logic [SW-1:0] STEP_LAST = SW'(MIX_STEPS - 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_INIT   = 3'd1;
   localparam logic [2:0] ST_MIX_A  = 3'd2;
   localparam logic [2:0] ST_MIX_B  = 3'd3;
   localparam logic [2:0] ST_CIPHER = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   // Control state
   logic [2:0]    state_ff, state_in;
   logic          table_ok_ff, table_ok_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [4:0]    key_len_ff, key_len_in;
   // Datapath
   logic [31:0]   key_word_ff [rc5_pkg::KEY_WORDS];
   logic [31:0]   key_l_ff    [rc5_pkg::KEY_WORDS];
   logic [31:0]   key_l_in    [rc5_pkg::KEY_WORDS];
   logic [1:0]    j_ff, j_in;
   logic [1:0]    j_last_ff, j_last_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [SW-1:0] step_ff, step_in;
   logic [31:0]   a_ff, a_in;
   logic [31:0]   b_ff, b_in;
   logic [1:0]    mode_ff, mode_in;
   logic [63:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_flag_ff, rsp_flag_in;

   // RAM ports
   logic          mem_wr_en;
   logic [IW-1:0] mem_wr_addr;
   logic [31:0]   mem_wr_data;
   logic [IW-1:0] mem_rd_addr;
   logic [31:0]   mem_rd_data;

   // Helpers
   logic          req_xfer;
   logic          out_free;
   logic [31:0]   subkey;
   logic [31:0]   ab_sum;
   logic [31:0]   mix_a;
   logic [31:0]   mix_b;
   logic [IW-1:0] idx_wrap;
   logic [4:0]    len_sat;
   logic [5:0]    len_round;
   logic [31:0]   key_masked [rc5_pkg::KEY_WORDS];

   rc5_ram #(
      .WIDTH (32),
      .DEPTH (TABLE_WORDS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_flag_ff;

   // Table reads as zero until first loaded
   assign subkey   = table_ok_ff ? mem_rd_data : 32'd0;
   assign ab_sum   = a_ff + b_ff;
   assign mix_a    = rc5_pkg::rotl32(subkey + ab_sum, 5'd3);
   assign mix_b    = rc5_pkg::rotl32(key_l_ff[j_ff] + ab_sum, ab_sum[4:0]);
   assign idx_wrap = (idx_ff == IDX_LAST) ? '0 : idx_ff + IW'(1);

   // Key bytes beyond the length are dropped
   assign len_sat   = (key_len_ff > rc5_pkg::MAX_KEY_BYTES) ? rc5_pkg::MAX_KEY_BYTES
                                                           : key_len_ff;
   assign len_round = {1'b0, len_sat} + 6'd3;
   always_comb begin
      for (int k = 0; k < rc5_pkg::KEY_WORDS; k++) begin
         for (int n = 0; n < 4; n++) begin
            key_masked[k][8*n +: 8] = ({1'b0, len_sat} > 6'(4*k + n)) ?
                                      key_word_ff[k][8*n +: 8] : 8'd0;
         end
      end
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in     = state_ff;
      table_ok_in  = table_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      key_l_in     = key_l_ff;
      j_in         = j_ff;
      j_last_in    = j_last_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mode_in      = mode_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_flag_in  = rsp_flag_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = idx_ff;
      mem_wr_data  = a_ff;
      mem_rd_addr  = idx_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               mode_in = req_tuser;
               a_in    = req_tdata[31:0];
               b_in    = req_tdata[63:32];
               unique case (req_tuser)
                  rc5_pkg::MODE_EXPAND: begin
                     state_in  = ST_INIT;
                     idx_in    = '0;
                     a_in      = rc5_pkg::MAGIC_P;
                     key_l_in  = key_masked;
                     j_in      = 2'd0;
                     j_last_in = (len_round[5:2] == 4'd0) ? 2'd0 : 2'(len_round[5:2] - 4'd1);
                  end
                  rc5_pkg::MODE_ENCRYPT: begin
                     state_in    = ST_CIPHER;
                     idx_in      = '0;
                     mem_rd_addr = '0;
                  end
                  rc5_pkg::MODE_DECRYPT: begin
                     state_in    = ST_CIPHER;
                     idx_in      = IDX_LAST;
                     mem_rd_addr = IDX_LAST;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_INIT: begin
            // S[i] = P + i*Q, one word per cycle
            mem_wr_en   = 1'b1;
            mem_wr_data = a_ff;
            a_in        = a_ff + rc5_pkg::MAGIC_Q;
            idx_in      = idx_wrap;
            mem_rd_addr = '0;
            if (idx_ff == IDX_LAST) begin
               state_in    = ST_MIX_A;
               table_ok_in = 1'b1;
               a_in        = 32'd0;
               b_in        = 32'd0;
               step_in     = '0;
            end
         end
         ST_MIX_A: begin
            // subkey update, written back in place
            a_in        = mix_a;
            mem_wr_en   = 1'b1;
            mem_wr_data = mix_a;
            state_in    = ST_MIX_B;
         end
         ST_MIX_B: begin
            // key word update, fetch next subkey
            b_in           = mix_b;
            key_l_in[j_ff] = mix_b;
            j_in           = (j_ff == j_last_ff) ? 2'd0 : j_ff + 2'd1;
            idx_in         = idx_wrap;
            mem_rd_addr    = idx_wrap;
            step_in        = step_ff + SW'(1);
            state_in       = (step_ff == STEP_LAST) ? ST_DONE : ST_MIX_A;
         end
         ST_CIPHER: begin
            // one half-round per cycle, next subkey fetched meanwhile
            if (mode_ff == rc5_pkg::MODE_ENCRYPT) begin
               if (idx_ff == '0) begin
                  a_in = a_ff + subkey;
               end else if (idx_ff == IW'(1)) begin
                  b_in = b_ff + subkey;
               end else if (!idx_ff[0]) begin
                  a_in = rc5_pkg::rotl32(a_ff ^ b_ff, b_ff[4:0]) + subkey;
               end else begin
                  b_in = rc5_pkg::rotl32(b_ff ^ a_ff, a_ff[4:0]) + subkey;
               end
               idx_in      = idx_ff + IW'(1);
               mem_rd_addr = idx_ff + IW'(1);
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_DONE;
               end
            end else begin
               if (idx_ff == '0) begin
                  a_in = a_ff - subkey;
               end else if (idx_ff == IW'(1)) begin
                  b_in = b_ff - subkey;
               end else if (idx_ff[0]) begin
                  b_in = rc5_pkg::rotr32(b_ff - subkey, a_ff[4:0]) ^ a_ff;
               end else begin
                  a_in = rc5_pkg::rotr32(a_ff - subkey, b_ff[4:0]) ^ b_ff;
               end
               idx_in      = idx_ff - IW'(1);
               mem_rd_addr = idx_ff - IW'(1);
               if (idx_ff == '0) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // hand the result to the output register once it is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = (mode_ff == rc5_pkg::MODE_EXPAND);
               if (mode_ff == rc5_pkg::MODE_ENCRYPT || mode_ff == rc5_pkg::MODE_DECRYPT) begin
                  rsp_data_in = {b_ff, a_ff};
               end else begin
                  rsp_data_in = 64'd0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration writes
   always_comb begin
      key_len_in = key_len_ff;
      if (csr_we && csr_index == rc5_pkg::CSR_KEY_LENGTH) begin
         key_len_in = csr_wdata[4:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         table_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         key_len_ff   <= rc5_pkg::KEY_LEN_RESET;
         for (int k = 0; k < rc5_pkg::KEY_WORDS; k++) begin
            key_word_ff[k] <= 32'd0;
         end
      end else begin
         state_ff     <= state_in;
         table_ok_ff  <= table_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         key_len_ff   <= key_len_in;
         if (csr_we) begin
            unique case (csr_index)
               rc5_pkg::CSR_KEY_WORD_0: key_word_ff[0] <= csr_wdata;
               rc5_pkg::CSR_KEY_WORD_1: key_word_ff[1] <= csr_wdata;
               rc5_pkg::CSR_KEY_WORD_2: key_word_ff[2] <= csr_wdata;
               rc5_pkg::CSR_KEY_WORD_3: key_word_ff[3] <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      key_l_ff    <= key_l_in;
      j_ff        <= j_in;
      j_last_ff   <= j_last_in;
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      mode_ff     <= mode_in;
      rsp_data_ff <= rsp_data_in;
      rsp_flag_ff <= rsp_flag_in;
   end

   // Table is written only while loading or mixing
   assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_INIT || state_ff == ST_MIX_A))
      else $error("subkey table written outside key expansion");

   // One item at a time
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("request taken while busy");

   // A new result only comes from the finishing step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("result raised outside finishing step");

   // Once loaded, the table stays valid until reset
   assert property (@(posedge clock) disable iff (reset)
      table_ok_ff |=> table_ok_ff)
      else $error("subkey table valid flag dropped");

endmodule

// ===== verif/rc5_block_cipher_checker.sv =====
`timescale 1ns / 1ps

// Watches the key registers and both streams of the RC5 block, predicts each result
// from its own copy of the key and subkey table, and compares in order.
module rc5_block_cipher_checker #(
   parameter int ROUNDS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] block_a, [63:32] block_b
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [31:0] result_a, [63:32] result_b
   input  logic        rsp_tuser,   // [0] expand_done
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatch_count,
   output int          results_pending
);

   localparam int SUBKEY_WORDS = 2 * (ROUNDS + 1);

   typedef struct packed {
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic        expand_done;
   } cipher_result_type;

   logic [31:0]       key_reg [rc5_pkg::KEY_WORDS];
   logic [4:0]        key_len;
   logic [31:0]       round_keys [SUBKEY_WORDS];
   cipher_result_type expected_results [$];
   cipher_result_type oldest;
   int                errors = 0;

   function automatic logic [31:0] rot_l(input logic [31:0] x, input logic [4:0] n);
      if (n == 5'd0) return x;
      return (x << n) | (x >> (32 - int'(n)));
   endfunction

   function automatic logic [31:0] rot_r(input logic [31:0] x, input logic [4:0] n);
      if (n == 5'd0) return x;
      return (x >> n) | (x << (32 - int'(n)));
   endfunction

   // Key schedule: fill with P/Q progression, then 3*max(t,c) mixing steps
   function automatic void expand_round_keys();
      logic [31:0] key_words [rc5_pkg::KEY_WORDS];
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] sum;
      int          len;
      int          used;
      int          words;
      int          steps;
      int          i;
      int          j;
      len = (key_len > rc5_pkg::MAX_KEY_BYTES) ? int'(rc5_pkg::MAX_KEY_BYTES) : int'(key_len);
      words = (len + 3) / 4;
      if (words == 0) words = 1;
      // bytes past the key length read as zero
      for (int k = 0; k < rc5_pkg::KEY_WORDS; k++) begin
         used = (len > 4 * k) ? len - 4 * k : 0;
         if (used >= 4)
            key_words[k] = key_reg[k];
         else if (used == 0)
            key_words[k] = 32'd0;
         else
            key_words[k] = key_reg[k] & ((32'd1 << (8 * used)) - 32'd1);
      end
      round_keys[0] = rc5_pkg::MAGIC_P;
      for (int k = 1; k < SUBKEY_WORDS; k++)
         round_keys[k] = round_keys[k - 1] + rc5_pkg::MAGIC_Q;
      steps = 3 * ((SUBKEY_WORDS > words) ? SUBKEY_WORDS : words);
      a = 32'd0;
      b = 32'd0;
      i = 0;
      j = 0;
      for (int k = 0; k < steps; k++) begin
         a = rot_l(round_keys[i] + a + b, 5'd3);
         round_keys[i] = a;
         sum = a + b;
         b = rot_l(key_words[j] + sum, sum[4:0]);
         key_words[j] = b;
         i = (i + 1) % SUBKEY_WORDS;
         j = (j + 1) % words;
      end
   endfunction

   // Result of one request; expansion updates the table as a side effect
   function automatic cipher_result_type cipher_result(input rc5_pkg::mode_type mode,
                                                       input logic [31:0] a_in,
                                                       input logic [31:0] b_in);
      cipher_result_type res;
      logic [31:0]       a;
      logic [31:0]       b;
      res = '0;
      a = a_in;
      b = b_in;
      case (mode)
         rc5_pkg::MODE_EXPAND: begin
            expand_round_keys();
            res.expand_done = 1'b1;
         end
         rc5_pkg::MODE_ENCRYPT: begin
            a = a + round_keys[0];
            b = b + round_keys[1];
            for (int r = 1; r <= ROUNDS; r++) begin
               a = rot_l(a ^ b, b[4:0]) + round_keys[2 * r];
               b = rot_l(b ^ a, a[4:0]) + round_keys[2 * r + 1];
            end
            res.word_a = a;
            res.word_b = b;
         end
         rc5_pkg::MODE_DECRYPT: begin
            for (int r = ROUNDS; r > 0; r--) begin
               b = rot_r(b - round_keys[2 * r + 1], a[4:0]) ^ a;
               a = rot_r(a - round_keys[2 * r], b[4:0]) ^ b;
            end
            res.word_a = a - round_keys[0];
            res.word_b = b - round_keys[1];
         end
         default: ;  // unused mode: zero result, no state change
      endcase
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rc5_pkg::KEY_WORDS; k++) key_reg[k] = 32'd0;
         key_len = rc5_pkg::KEY_LEN_RESET;
         for (int k = 0; k < SUBKEY_WORDS; k++) round_keys[k] = 32'd0;
         expected_results.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               rc5_pkg::CSR_KEY_WORD_0: key_reg[0] = csr_wdata;
               rc5_pkg::CSR_KEY_WORD_1: key_reg[1] = csr_wdata;
               rc5_pkg::CSR_KEY_WORD_2: key_reg[2] = csr_wdata;
               rc5_pkg::CSR_KEY_WORD_3: key_reg[3] = csr_wdata;
               rc5_pkg::CSR_KEY_LENGTH: key_len = csr_wdata[4:0];
               default: ;
            endcase
         end
         // result transfer against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %h/%h flag %b with none pending",
                                         rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser));
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_tdata[31:0] !== oldest.word_a)
                  report_mismatch($sformatf("result_a %h, predicted %h",
                                            rsp_tdata[31:0], oldest.word_a));
               if (rsp_tdata[63:32] !== oldest.word_b)
                  report_mismatch($sformatf("result_b %h, predicted %h",
                                            rsp_tdata[63:32], oldest.word_b));
               if (rsp_tuser !== oldest.expand_done)
                  report_mismatch($sformatf("expand_done %b, predicted %b",
                                            rsp_tuser, oldest.expand_done));
            end
         end
         // request transfer: predict now, requests complete in order
         if (req_tvalid && req_tready)
            expected_results.push_back(cipher_result(req_tuser, req_tdata[31:0],
                                                     req_tdata[63:32]));
      end
      mismatch_count  <= errors;
      results_pending <= expected_results.size();
   end

endmodule

// ===== verif/rc5_block_cipher_tb.sv =====
`timescale 1ns / 1ps

module rc5_block_cipher_tb;

   localparam int ROUNDS         = 12;
   localparam int ITEM_TARGET    = 1500;
   localparam int QUIET_TAIL     = 150;
   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;   // [31:0] block_a, [63:32] block_b
   logic [1:0]  req_tuser  = '0;   // [1:0] mode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;         // [31:0] result_a, [63:32] result_b
   logic        rsp_tuser;         // [0] expand_done
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [31:0] csr_wdata  = '0;

   int          mismatch_count;
   int          results_pending;
   int          sent_count = 0;
   int          quiet_cycles = 0;
   int          stall_left = 0;
   bit          idle_on = 1'b1;

   rc5_block_cipher #(
      .ROUNDS(ROUNDS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   rc5_block_cipher_checker #(
      .ROUNDS(ROUNDS)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_pending(results_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // result side backpressure: stall bursts of random length
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 6) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // one request transfer, with an optional gap in front
   task automatic send_item(input rc5_pkg::mode_type mode, input logic [31:0] a,
                            input logic [31:0] b);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= mode;
      do @(posedge clock); while (!req_tready);
      sent_count++;
   endtask

   // stop sending and let every pending result come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input rc5_pkg::csr_index_type index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // all key registers in one burst; block must be idle
   task automatic load_key(input logic [31:0] k0, input logic [31:0] k1, input logic [31:0] k2,
                           input logic [31:0] k3, input logic [4:0] len);
      write_csr(rc5_pkg::CSR_KEY_WORD_0, k0);
      write_csr(rc5_pkg::CSR_KEY_WORD_1, k1);
      write_csr(rc5_pkg::CSR_KEY_WORD_2, k2);
      write_csr(rc5_pkg::CSR_KEY_WORD_3, k3);
      write_csr(rc5_pkg::CSR_KEY_LENGTH, {27'd0, len});
      csr_we <= 1'b0;
   endtask

   task automatic rekey_and_probe(input logic [31:0] fill, input logic [4:0] len,
                                  input rc5_pkg::mode_type mode);
      wait_for_results();
      load_key(fill, fill, fill, fill, len);
      send_item(rc5_pkg::MODE_EXPAND, 32'd0, 32'd0);
      send_item(mode, pick_word(), pick_word());
   endtask

   initial begin
      logic [4:0] len;
      int         phase_items;
      int         pick;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero table straight out of reset, plus the unused mode
      send_item(rc5_pkg::MODE_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_item(rc5_pkg::MODE_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
      send_item(rc5_pkg::MODE_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      send_item(rc5_pkg::MODE_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
      send_item(rc5_pkg::MODE_UNUSED, 32'hffff_ffff, 32'hffff_ffff);

      // expansion with the reset key registers
      send_item(rc5_pkg::MODE_EXPAND, 32'hffff_ffff, 32'hffff_ffff);
      send_item(rc5_pkg::MODE_ENCRYPT, 32'h0000_0000, 32'h0000_0000);

      // full 16-byte key; unused mode must leave the table alone
      wait_for_results();
      load_key(32'h0302_0100, 32'h0706_0504, 32'h0b0a_0908, 32'h0f0e_0d0c, 5'd16);
      send_item(rc5_pkg::MODE_EXPAND, 32'd0, 32'd0);
      send_item(rc5_pkg::MODE_ENCRYPT, 32'h0000_0000, 32'h0000_0000);
      send_item(rc5_pkg::MODE_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff);
      send_item(rc5_pkg::MODE_DECRYPT, 32'h0000_0000, 32'h0000_0000);
      send_item(rc5_pkg::MODE_DECRYPT, 32'hffff_ffff, 32'hffff_ffff);
      send_item(rc5_pkg::MODE_UNUSED, 32'h1234_5678, 32'h9abc_def0);
      send_item(rc5_pkg::MODE_ENCRYPT, 32'h1234_5678, 32'h9abc_def0);

      // zero length, saturated length, partial last word
      rekey_and_probe(32'hffff_ffff, 5'd0, rc5_pkg::MODE_ENCRYPT);
      rekey_and_probe(32'hffff_ffff, 5'd31, rc5_pkg::MODE_ENCRYPT);
      rekey_and_probe(32'hffff_ffff, 5'd17, rc5_pkg::MODE_DECRYPT);
      rekey_and_probe(32'hffff_ffff, 5'd5, rc5_pkg::MODE_DECRYPT);
      rekey_and_probe(32'ha5c3_5a3c, 5'd1, rc5_pkg::MODE_ENCRYPT);

      // random phases: new key, usually an expansion, then mostly block traffic
      while (sent_count < ITEM_TARGET) begin
         wait_for_results();
         idle_on = (sent_count < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 9))
            0:       len = 5'd0;
            1:       len = 5'd16;
            2:       len = 5'($urandom_range(17, 31));
            default: len = 5'($urandom_range(1, 16));
         endcase
         load_key(pick_word(), pick_word(), pick_word(), pick_word(), len);
         if ($urandom_range(0, 9) != 0)
            send_item(rc5_pkg::MODE_EXPAND, $urandom, $urandom);
         phase_items = $urandom_range(20, 80);
         for (int n = 0; n < phase_items; n++) begin
            pick = $urandom_range(0, 39);
            if (pick == 0)
               send_item(rc5_pkg::MODE_EXPAND, $urandom, $urandom);
            else if (pick == 1)
               send_item(rc5_pkg::MODE_UNUSED, pick_word(), pick_word());
            else if (pick < 20)
               send_item(rc5_pkg::MODE_ENCRYPT, pick_word(), pick_word());
            else
               send_item(rc5_pkg::MODE_DECRYPT, pick_word(), pick_word());
         end
      end

      // drain and give the block time to show any stray result
      wait_for_results();
      repeat (200) @(posedge clock);
      if (mismatch_count == 0 && results_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rc5_pkg.sv
rtl/core/rc5_ram.sv
rtl/core/rc5_block_cipher.sv
verif/rc5_block_cipher_checker.sv
verif/rc5_block_cipher_tb.sv
